// File: hw/rtl/kcl_pkg.sv
// Shared types and constants for the keypad code lock.
package kcl_pkg;

  // Number of keys in one code.
  localparam int CODE_LENGTH = 4;
  localparam int KCNT_W      = $clog2(CODE_LENGTH + 1);

  // Item kinds.
  localparam logic OP_KEY   = 1'b0;
  localparam logic OP_RANGE = 1'b1;

  // Special keys.
  localparam logic [7:0] KEY_START  = 8'h23;  // '#'
  localparam logic [7:0] KEY_SUBMIT = 8'h2A;  // '*'

  // Servo pulse widths in PWM steps.
  localparam logic [7:0] DUTY_CLOSED = 8'd18;
  localparam logic [7:0] DUTY_OPEN   = 8'd5;

  // Register map: index is paddr[2].
  localparam int          PADDR_W        = 3;
  localparam logic        REG_ACCESS     = 1'b0;
  localparam logic        REG_NEAR_ECHO  = 1'b1;
  localparam logic [31:0] ACCESS_RESET   = 32'h3132_3334;
  localparam logic [15:0] NEAR_RESET     = 16'd580;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_START    = 3'd1,
    ST_STORED   = 3'd2,
    ST_UNLOCKED = 3'd3,
    ST_WRONG    = 3'd4,
    ST_LOCKED   = 3'd5,
    ST_DROPPED  = 3'd6
  } kcl_status_t;

  typedef struct packed {
    kcl_status_t status;
    logic        locked;
    logic        entering;
    logic [7:0]  duty;
  } kcl_result_t;

endpackage

// File: hw/rtl/kcl_ctrl.sv
// Lock state, key buffer and per-item decision logic.
module kcl_ctrl
  import kcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        operation,
  input  logic [7:0]  key_char,
  input  logic [15:0] echo_us,
  input  logic [31:0] access_code,
  input  logic [15:0] near_echo_us,
  output kcl_result_t result
);

  logic              entering;
  logic              locked;
  logic [KCNT_W-1:0] key_count;
  logic [7:0]        keys [CODE_LENGTH];

  logic              entering_next;
  logic              locked_next;
  logic              clear_keys;
  logic              store_key;
  logic              match;
  kcl_status_t       status;

  // Compare every stored key against its code byte.
  always_comb begin
    match = 1'b1;
    for (int k = 0; k < CODE_LENGTH; k++) begin
      if (keys[k] != 8'(access_code >> (8 * (CODE_LENGTH - 1 - k)))) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    entering_next = entering;
    locked_next   = locked;
    clear_keys    = 1'b0;
    store_key     = 1'b0;
    status        = ST_NONE;
    if (operation == OP_KEY) begin
      if (!entering) begin
        if (key_char == KEY_START) begin
          entering_next = 1'b1;
          clear_keys    = 1'b1;
          status        = ST_START;
        end
      end else if (key_char == KEY_SUBMIT) begin
        clear_keys = 1'b1;
        if (match) begin
          locked_next   = 1'b0;
          entering_next = 1'b0;
          status        = ST_UNLOCKED;
        end else begin
          status = ST_WRONG;
        end
      end else if (key_count < KCNT_W'(CODE_LENGTH)) begin
        store_key = 1'b1;
        status    = ST_STORED;
      end else begin
        status = ST_DROPPED;
      end
    end else if (!entering && !locked && echo_us < near_echo_us) begin
      locked_next = 1'b1;
      status      = ST_LOCKED;
    end
  end

  assign result.status   = status;
  assign result.locked   = locked_next;
  assign result.entering = entering_next;
  assign result.duty     = locked_next ? DUTY_CLOSED : DUTY_OPEN;

  always_ff @(posedge clk) begin
    if (rst) begin
      entering  <= 1'b0;
      locked    <= 1'b0;
      key_count <= '0;
      for (int k = 0; k < CODE_LENGTH; k++) begin
        keys[k] <= '0;
      end
    end else if (adv) begin
      entering <= entering_next;
      locked   <= locked_next;
      if (clear_keys) begin
        key_count <= '0;
        for (int k = 0; k < CODE_LENGTH; k++) begin
          keys[k] <= '0;
        end
      end else if (store_key) begin
        key_count <= key_count + KCNT_W'(1);
        for (int k = 0; k < CODE_LENGTH; k++) begin
          if (key_count == KCNT_W'(k)) begin
            keys[k] <= key_char;
          end
        end
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    key_count <= KCNT_W'(CODE_LENGTH))
    else $error("key count beyond code length");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !entering |-> key_count == '0)
    else $error("key buffer not empty while idle");

  a_lock_by_range: assert property (@(posedge clk) disable iff (rst)
    $rose(locked) |-> $past(adv && operation == OP_RANGE))
    else $error("lock closed without a range item");

  a_unlock_state: assert property (@(posedge clk) disable iff (rst)
    (adv && status == ST_UNLOCKED) |=> !entering && !locked)
    else $error("unlock did not open lock and end entry");

endmodule

// File: hw/rtl/keypad_code_lock.sv
// Top level of the keypad code lock: input stage, control, result stage, registers.
//
// Keypad code lock with a proximity latch. Each input item is a key press
// (operation 0, key_char) or a range measurement (operation 1, echo_us) and
// produces exactly one result item. While idle, '#' starts code entry; during
// entry every other key but '*' is stored, up to four, and later keys are
// dropped; '*' submits, opening the lock and ending entry on a match, else
// clearing the buffer. While idle and open, an echo shorter than near_echo_us
// closes the lock. A new item is taken every cycle while in_stall is low; an
// accepted item is registered in the input register, then moves into the
// result register when it is empty or drains; the result holds while out_stall
// is high. in_stall rises only when both stages are full and the result is
// stalled. Registers: access_code at byte address 0 (first key in the top
// byte), near_echo_us at 4; write them only while no item is in flight.
module keypad_code_lock
  import kcl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [7:0]         key_char,
  input  logic [15:0]        echo_us,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic               locked_now,
  output logic               entering_now,
  output logic [7:0]         servo_duty,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers.
  logic [31:0] access_code;
  logic [15:0] near_echo_us;

  // Input stage.
  logic        s1_valid;
  logic        s1_operation;
  logic [7:0]  s1_key_char;
  logic [15:0] s1_echo_us;

  logic        s1_take;
  logic        in_take;
  kcl_result_t result;
  kcl_result_t out_q;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      access_code  <= ACCESS_RESET;
      near_echo_us <= NEAR_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ACCESS:    access_code  <= pwdata;
        REG_NEAR_ECHO: near_echo_us <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ACCESS:    prdata = access_code;
      REG_NEAR_ECHO: prdata = {16'd0, near_echo_us};
      default:       prdata = '0;
    endcase
  end

  // Advance the input stage whenever the result register is empty or drains.
  assign s1_take  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_take;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !s1_take);
    end
  end

  // Payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_operation <= operation;
      s1_key_char  <= key_char;
      s1_echo_us   <= echo_us;
    end
  end

  kcl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .adv          (s1_take),
    .operation    (s1_operation),
    .key_char     (s1_key_char),
    .echo_us      (s1_echo_us),
    .access_code  (access_code),
    .near_echo_us (near_echo_us),
    .result       (result)
  );

  // Result register: fill on advance, drop when taken downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_q <= result;
    end
  end

  assign status       = out_q.status;
  assign locked_now   = out_q.locked;
  assign entering_now = out_q.entering;
  assign servo_duty   = out_q.duty;

endmodule
